// ----- rtl/hoca_pkg.sv -----
// Shared types and constants of the HSV offset color adjust pipeline.
`default_nettype none
package hoca_pkg;
   localparam int CHAN_W = 12;
   localparam int OFS_W  = 14;
   localparam int DIV_W  = 15;
   localparam logic [CHAN_W-1:0] OUT_MAX = 12'hFFF;

   localparam logic [2:0] SEC_0 = 3'd0;
   localparam logic [2:0] SEC_1 = 3'd1;
   localparam logic [2:0] SEC_2 = 3'd2;
   localparam logic [2:0] SEC_3 = 3'd3;
   localparam logic [2:0] SEC_4 = 3'd4;

   typedef struct packed {
      logic              grey;
      logic [CHAN_W-1:0] mx;
      logic [OFS_W-1:0]  hoff;
      logic [OFS_W-1:0]  soff;
      logic [OFS_W-1:0]  voff;
   } side_type;

   typedef struct packed {
      logic [DIV_W-1:0] num_s;
      logic [DIV_W-1:0] den_s;
      logic [DIV_W-1:0] num_h;
      logic [DIV_W-1:0] den_h;
      side_type         side;
   } div_req_type;
endpackage
`default_nettype wire

// ----- rtl/hoca_front.sv -----
// Input register stage: max/min, chroma and hue numerator.
`default_nettype none
module hoca_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [hoca_pkg::CHAN_W-1:0]   red,
   input  wire logic [hoca_pkg::CHAN_W-1:0]   green,
   input  wire logic [hoca_pkg::CHAN_W-1:0]   blue,
   input  wire logic [hoca_pkg::OFS_W-1:0]    hoff,
   input  wire logic [hoca_pkg::OFS_W-1:0]    soff,
   input  wire logic [hoca_pkg::OFS_W-1:0]    voff,
   output logic                               out_valid,
   output hoca_pkg::div_req_type              out_req
);
   logic [hoca_pkg::CHAN_W-1:0] mx, mn, d;
   logic signed [16:0]          r_s, g_s, b_s, d_s, n_raw, n_adj, d6;
   logic                        grey;
   logic                        valid_ff;
   hoca_pkg::div_req_type       req_ff, req_in;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      d    = mx - mn;
      grey = (mx == mn);
      r_s  = signed'({5'b0, red});
      g_s  = signed'({5'b0, green});
      b_s  = signed'({5'b0, blue});
      d_s  = signed'({5'b0, d});
      d6   = (d_s <<< 2) + (d_s <<< 1);
      if (red == mx)
         n_raw = g_s - b_s;
      else if (green == mx)
         n_raw = (d_s <<< 1) + b_s - r_s;
      else
         n_raw = (d_s <<< 2) + r_s - g_s;
      n_adj = (n_raw < 0) ? n_raw + d6 : n_raw;
      req_in.num_s = grey ? '0 : hoca_pkg::DIV_W'(d);
      req_in.den_s = grey ? hoca_pkg::DIV_W'(1) : hoca_pkg::DIV_W'(mx);
      req_in.num_h = grey ? '0 : n_adj[hoca_pkg::DIV_W-1:0];
      req_in.den_h = grey ? hoca_pkg::DIV_W'(1) : d6[hoca_pkg::DIV_W-1:0];
      req_in.side.grey = grey;
      req_in.side.mx   = mx;
      req_in.side.hoff = hoff;
      req_in.side.soff = soff;
      req_in.side.voff = voff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= start;
      req_ff <= req_in;
   end

   assign out_valid = valid_ff;
   assign out_req   = req_ff;
endmodule
`default_nettype wire

// ----- rtl/hoca_div.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage: num*2^F/den.
`default_nettype none
module hoca_div #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  hoca_pkg::div_req_type       in_req,
   output logic                        out_valid,
   output logic [FRAC_BITS:0]          quo_s,
   output logic [FRAC_BITS:0]          quo_h,
   output hoca_pkg::side_type          out_side
);
   localparam int Q  = FRAC_BITS + 1;
   localparam int DW = hoca_pkg::DIV_W;

   logic [DW-1:0]      rem_s_ff [Q];
   logic [DW-1:0]      rem_h_ff [Q];
   logic [DW-1:0]      den_s_ff [Q];
   logic [DW-1:0]      den_h_ff [Q];
   logic [Q-1:0]       qs_ff    [Q];
   logic [Q-1:0]       qh_ff    [Q];
   hoca_pkg::side_type side_ff  [Q];
   logic [Q-1:0]       valid_ff;

   genvar k;
   generate
      for (k = 0; k < Q; k++) begin : g_stage
         logic [DW:0]   ts, th;
         logic [DW-1:0] ps, ph, pds, pdh;
         logic [Q-1:0]  pqs, pqh;
         logic          pv;
         hoca_pkg::side_type psd;
         logic [DW-1:0] rem_s_in, rem_h_in;
         logic [Q-1:0]  qs_in, qh_in;
         if (k == 0) begin : g_first
            assign ps  = in_req.num_s;
            assign ph  = in_req.num_h;
            assign pds = in_req.den_s;
            assign pdh = in_req.den_h;
            assign pqs = '0;
            assign pqh = '0;
            assign pv  = in_valid;
            assign psd = in_req.side;
            assign ts  = {1'b0, ps};
            assign th  = {1'b0, ph};
         end else begin : g_next
            assign ps  = rem_s_ff[k-1];
            assign ph  = rem_h_ff[k-1];
            assign pds = den_s_ff[k-1];
            assign pdh = den_h_ff[k-1];
            assign pqs = qs_ff[k-1];
            assign pqh = qh_ff[k-1];
            assign pv  = valid_ff[k-1];
            assign psd = side_ff[k-1];
            assign ts  = {ps, 1'b0};
            assign th  = {ph, 1'b0};
         end
         always_comb begin
            if (ts >= {1'b0, pds}) begin
               rem_s_in = DW'(ts - {1'b0, pds});
               qs_in    = {pqs[Q-2:0], 1'b1};
            end else begin
               rem_s_in = ts[DW-1:0];
               qs_in    = {pqs[Q-2:0], 1'b0};
            end
            if (th >= {1'b0, pdh}) begin
               rem_h_in = DW'(th - {1'b0, pdh});
               qh_in    = {pqh[Q-2:0], 1'b1};
            end else begin
               rem_h_in = th[DW-1:0];
               qh_in    = {pqh[Q-2:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (reset)
               valid_ff[k] <= 1'b0;
            else
               valid_ff[k] <= pv;
            rem_s_ff[k] <= rem_s_in;
            rem_h_ff[k] <= rem_h_in;
            den_s_ff[k] <= pds;
            den_h_ff[k] <= pdh;
            qs_ff[k]    <= qs_in;
            qh_ff[k]    <= qh_in;
            side_ff[k]  <= psd;
         end
      end
   endgenerate

   assign out_valid = valid_ff[Q-1];
   assign quo_s     = qs_ff[Q-1];
   assign quo_h     = qh_ff[Q-1];
   assign out_side  = side_ff[Q-1];
endmodule
`default_nettype wire

// ----- rtl/hoca_hsv2rgb.sv -----
// Offset/clamp of HSV and six-sector conversion back to RGB, five stages.
`default_nettype none
module hoca_hsv2rgb #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [FRAC_BITS:0]            quo_s,
   input  wire logic [FRAC_BITS:0]            quo_h,
   input  hoca_pkg::side_type                 in_side,
   output logic                               out_valid,
   output logic [hoca_pkg::CHAN_W-1:0]        red,
   output logic [hoca_pkg::CHAN_W-1:0]        green,
   output logic [hoca_pkg::CHAN_W-1:0]        blue
);
   localparam int F   = FRAC_BITS;
   localparam int W   = FRAC_BITS + 1;
   localparam int SW  = (FRAC_BITS > 13 ? FRAC_BITS : 13) + 3;
   localparam int EW  = (W > hoca_pkg::CHAN_W) ? W : hoca_pkg::CHAN_W;
   localparam logic [W-1:0]        ONE_U = W'(1) << F;
   localparam logic signed [SW-1:0] ONE_S = SW'(1) << F;
   localparam int OW = hoca_pkg::OFS_W;

   // stage A: offsets
   logic signed [SW-1:0] hs, ss, vs;
   logic [F-1:0]         hue_a_in;
   logic [W-1:0]         sat_a_in, val_a_in;
   logic                 va_ff;
   logic [F-1:0]         hue_a_ff;
   logic [W-1:0]         sat_a_ff, val_a_ff;

   always_comb begin
      hs = signed'(SW'(in_side.grey ? '0 : quo_h))
         + signed'({{(SW-OW){in_side.hoff[OW-1]}}, in_side.hoff});
      ss = signed'(SW'(in_side.grey ? '0 : quo_s))
         + signed'({{(SW-OW){in_side.soff[OW-1]}}, in_side.soff});
      vs = signed'(SW'(in_side.mx))
         + signed'({{(SW-OW){in_side.voff[OW-1]}}, in_side.voff});
      hue_a_in = hs[F-1:0];
      if (ss < 0)          sat_a_in = '0;
      else if (ss > ONE_S) sat_a_in = ONE_U;
      else                 sat_a_in = ss[W-1:0];
      if (vs < 0)          val_a_in = '0;
      else if (vs > ONE_S) val_a_in = ONE_U;
      else                 val_a_in = vs[W-1:0];
   end

   // stage B: sector and fraction
   logic [F+2:0] hh;
   logic         vb_ff;
   logic [2:0]   sec_b_ff;
   logic [F-1:0] f_b_ff;
   logic [W-1:0] omf_b_ff, sat_b_ff, val_b_ff;
   assign hh = (F+3)'(hue_a_ff) * (F+3)'(6);

   // stage C: saturation products
   logic [2*W-1:0] sf, sg;
   logic           vc_ff, zero_c_ff;
   logic [2:0]     sec_c_ff;
   logic [W-1:0]   ps_c_ff, qs_c_ff, ts_c_ff, val_c_ff;
   assign sf = (2*W)'(sat_b_ff) * (2*W)'(f_b_ff);
   assign sg = (2*W)'(sat_b_ff) * (2*W)'(omf_b_ff);

   // stage D: value products
   logic [2*W-1:0] pp, pq, pt;
   logic           vd_ff, zero_d_ff;
   logic [2:0]     sec_d_ff;
   logic [W-1:0]   p_d_ff, q_d_ff, t_d_ff, val_d_ff;
   assign pp = (2*W)'(val_c_ff) * (2*W)'(ps_c_ff);
   assign pq = (2*W)'(val_c_ff) * (2*W)'(qs_c_ff);
   assign pt = (2*W)'(val_c_ff) * (2*W)'(ts_c_ff);

   // stage E: sector select and output saturation
   logic [W-1:0] ro, go, bo;
   logic         ve_ff;
   logic [hoca_pkg::CHAN_W-1:0] r_ff, g_ff, b_ff;

   function automatic logic [hoca_pkg::CHAN_W-1:0] sat_out(input logic [W-1:0] x);
      logic [EW-1:0] t;
      t = EW'(x);
      if (t > EW'(hoca_pkg::OUT_MAX))
         return hoca_pkg::OUT_MAX;
      return t[hoca_pkg::CHAN_W-1:0];
   endfunction

   always_comb begin
      if (zero_d_ff) begin
         ro = val_d_ff; go = val_d_ff; bo = val_d_ff;
      end else begin
         case (sec_d_ff)
            hoca_pkg::SEC_0: begin ro = val_d_ff; go = t_d_ff;   bo = p_d_ff;   end
            hoca_pkg::SEC_1: begin ro = q_d_ff;   go = val_d_ff; bo = p_d_ff;   end
            hoca_pkg::SEC_2: begin ro = p_d_ff;   go = val_d_ff; bo = t_d_ff;   end
            hoca_pkg::SEC_3: begin ro = p_d_ff;   go = q_d_ff;   bo = val_d_ff; end
            hoca_pkg::SEC_4: begin ro = t_d_ff;   go = p_d_ff;   bo = val_d_ff; end
            default:         begin ro = val_d_ff; go = p_d_ff;   bo = q_d_ff;   end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
      hue_a_ff  <= hue_a_in;
      sat_a_ff  <= sat_a_in;
      val_a_ff  <= val_a_in;
      sec_b_ff  <= hh[F+2:F];
      f_b_ff    <= hh[F-1:0];
      omf_b_ff  <= ONE_U - W'(hh[F-1:0]);
      sat_b_ff  <= sat_a_ff;
      val_b_ff  <= val_a_ff;
      zero_c_ff <= (sat_b_ff == '0);
      sec_c_ff  <= sec_b_ff;
      ps_c_ff   <= ONE_U - sat_b_ff;
      qs_c_ff   <= ONE_U - sf[F+W-1:F];
      ts_c_ff   <= ONE_U - sg[F+W-1:F];
      val_c_ff  <= val_b_ff;
      zero_d_ff <= zero_c_ff;
      sec_d_ff  <= sec_c_ff;
      p_d_ff    <= pp[F+W-1:F];
      q_d_ff    <= pq[F+W-1:F];
      t_d_ff    <= pt[F+W-1:F];
      val_d_ff  <= val_c_ff;
      r_ff      <= sat_out(ro);
      g_ff      <= sat_out(go);
      b_ff      <= sat_out(bo);
   end

   assign out_valid = ve_ff;
   assign red       = r_ff;
   assign green     = g_ff;
   assign blue      = b_ff;
endmodule
`default_nettype wire

// ----- rtl/hsv_offset_color_adjust.sv -----
// Top level: RGB pixel to HSV, add offsets, back to RGB.
// One pixel is taken on every clock cycle that start is high; busy is never
// raised. Each result appears on rsp_* with rsp_valid high for one cycle,
// after passing through one input register, FRAC_BITS + 1 divider stages
// that yield one quotient bit each for saturation and hue, and five stages
// for offsets, sector, products and output select. Results leave in input
// order and cannot be held off.
`default_nettype none
module hsv_offset_color_adjust #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [hoca_pkg::CHAN_W-1:0]   req_red_in,
   input  wire logic [hoca_pkg::CHAN_W-1:0]   req_green_in,
   input  wire logic [hoca_pkg::CHAN_W-1:0]   req_blue_in,
   input  wire logic [hoca_pkg::OFS_W-1:0]    req_hue_offset,
   input  wire logic [hoca_pkg::OFS_W-1:0]    req_sat_offset,
   input  wire logic [hoca_pkg::OFS_W-1:0]    req_val_offset,
   output logic                               rsp_valid,
   output logic [hoca_pkg::CHAN_W-1:0]        rsp_red_out,
   output logic [hoca_pkg::CHAN_W-1:0]        rsp_green_out,
   output logic [hoca_pkg::CHAN_W-1:0]        rsp_blue_out
);
   logic                  fr_valid, dv_valid;
   hoca_pkg::div_req_type fr_req;
   logic [FRAC_BITS:0]    quo_s, quo_h;
   hoca_pkg::side_type    dv_side;

   assign busy = 1'b0;

   hoca_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .hoff      (req_hue_offset),
      .soff      (req_sat_offset),
      .voff      (req_val_offset),
      .out_valid (fr_valid),
      .out_req   (fr_req)
   );

   hoca_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_req    (fr_req),
      .out_valid (dv_valid),
      .quo_s     (quo_s),
      .quo_h     (quo_h),
      .out_side  (dv_side)
   );

   hoca_hsv2rgb #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .quo_s     (quo_s),
      .quo_h     (quo_h),
      .in_side   (dv_side),
      .out_valid (rsp_valid),
      .red       (rsp_red_out),
      .green     (rsp_green_out),
      .blue      (rsp_blue_out)
   );
endmodule
`default_nettype wire
